FILE: sv/tts_pkg.sv
// Shared types, codes and constants of the task table scheduler.
`timescale 1ns / 1ps
package tts_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int PID_W = 31;

  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd1013904223;
  localparam logic [7:0]  DEF_PRI   = 8'd60;
  localparam logic [15:0] DEF_BURST = 16'd5;

  localparam logic [2:0] POL_OLDEST   = 3'd0;
  localparam logic [2:0] POL_SHORTEST = 3'd1;
  localparam logic [2:0] POL_PRIORITY = 3'd2;
  localparam logic [2:0] POL_RANDOM   = 3'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFREE  = 2'd1;
  localparam logic [1:0] STAT_NOTFND  = 2'd2;
  localparam logic [1:0] STAT_NORUN   = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_DPRI   = 2'd1;
  localparam logic [1:0] REG_DBURST = 2'd2;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_EMBRYO   = 3'd1,
    ST_SLEEPING = 3'd2,
    ST_RUNNABLE = 3'd3,
    ST_RUNNING  = 3'd4,
    ST_ZOMBIE   = 3'd5
  } slot_st_t;

  typedef enum logic [3:0] {
    CMD_ALLOC  = 4'd0,
    CMD_RUN    = 4'd1,
    CMD_SLEEP  = 4'd2,
    CMD_WAKE   = 4'd3,
    CMD_KILL   = 4'd4,
    CMD_EXIT   = 4'd5,
    CMD_FREE   = 4'd6,
    CMD_SET    = 4'd7,
    CMD_PICK   = 4'd8
  } cmd_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_RD1,
    FS_MOD1,
    FS_SCAN,
    FS_FIN,
    FS_LCG,
    FS_DIV,
    FS_DONE
  } fsm_t;

  typedef struct packed {
    slot_st_t          st;
    logic [PID_W-1:0]  pid;
    logic              killed;
    logic [31:0]       created;
    logic [7:0]        pri;
    logic [15:0]       burst;
    logic [31:0]       chan;
  } entry_t;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [5:0]        slot;
    logic [PID_W-1:0]  tpid;
    logic [31:0]       chan;
    logic [31:0]       tick;
    logic [7:0]        pri;
    logic [15:0]       burst;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        slot;
    logic [PID_W-1:0]  pid;
  } rsp_t;

  typedef struct packed {
    logic [2:0]        policy;
    logic [7:0]        dpri;
    logic [15:0]       dburst;
  } cfg_t;

endpackage

FILE: sv/tts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tts_engine.sv
// Command sequencer: scans the slot table memory and applies read-modify-write updates.
`timescale 1ns / 1ps
module tts_engine import tts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  req_t  req,
  input  cfg_t  cfg,
  output logic  done,
  input  logic  done_ack,
  output rsp_t  rsp
);

  fsm_t             state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             rv_r, rv_nxt;
  logic             rvld_r, rvld_nxt;
  logic [IDX_W-1:0] ridx_r, ridx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_r, best_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0] target_r, target_nxt;
  logic             pass2_r, pass2_nxt;
  logic [31:0]      lcg_r, lcg_nxt;
  logic [31:0]      dq_r, dq_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [4:0]       dbit_r, dbit_nxt;
  logic [PID_W-1:0] pidc_r, pidc_nxt;
  logic [IDX_W-1:0] rr_r, rr_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  rsp_t             rsp_r, rsp_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, eff;
  logic [$bits(entry_t)-1:0] rdata;
  logic             issue, scan_end, is_rand, in_use;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_new;

  tts_ram #(.DEPTH(SLOTS), .WIDTH($bits(entry_t))) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign is_rand  = (req_r.cmd == CMD_PICK) && (cfg.policy == POL_RANDOM);
  assign scan_end = (rd_cnt_r == CNT_W'(SLOTS)) && !rv_r;
  assign rem_sh   = {rem_r, dq_r[31]};
  assign rem_new  = (rem_sh >= {1'b0, cnt_r}) ? rem_sh - {1'b0, cnt_r} : rem_sh;

  always_comb begin
    eff = entry_t'(rdata);
    if (!rvld_r) begin
      eff.st     = ST_UNUSED;
      eff.pid    = '0;
      eff.killed = 1'b0;
    end
  end

  assign in_use = eff.st != ST_UNUSED;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          if (req.cmd inside {CMD_ALLOC, CMD_WAKE, CMD_KILL, CMD_PICK}) begin
            state_nxt = FS_SCAN;
          end else if (req.cmd inside {CMD_RUN, CMD_SLEEP, CMD_EXIT, CMD_FREE, CMD_SET}) begin
            state_nxt = (32'(req.slot) < SLOTS) ? FS_RD1 : FS_DONE;
          end else begin
            state_nxt = FS_DONE;
          end
        end
      end
      FS_RD1:  state_nxt = FS_MOD1;
      FS_MOD1: state_nxt = FS_DONE;
      FS_SCAN: if (scan_end) state_nxt = FS_FIN;
      FS_FIN: begin
        if (is_rand && !pass2_r && cnt_r != '0) begin
          state_nxt = FS_LCG;
        end else begin
          state_nxt = FS_DONE;
        end
      end
      FS_LCG:  state_nxt = FS_DIV;
      FS_DIV:  if (dbit_r == 5'd31) state_nxt = FS_SCAN;
      FS_DONE: if (done_ack) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    int a;
    int b;
    logic better;
    req_nxt      = req_r;
    rd_cnt_nxt   = rd_cnt_r;
    rv_nxt       = 1'b0;
    rvld_nxt     = rvld_r;
    ridx_nxt     = ridx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    cnt_nxt      = cnt_r;
    seen_nxt     = seen_r;
    target_nxt   = target_r;
    pass2_nxt    = pass2_r;
    lcg_nxt      = lcg_r;
    dq_nxt       = dq_r;
    rem_nxt      = rem_r;
    dbit_nxt     = dbit_r;
    pidc_nxt     = pidc_r;
    rr_nxt       = rr_r;
    valid_nxt    = valid_r;
    rsp_nxt      = rsp_r;
    we           = 1'b0;
    waddr        = ridx_r;
    wdata        = eff;
    raddr        = IDX_W'(rd_cnt_r);
    issue        = 1'b0;
    better       = 1'b0;
    a            = 0;
    b            = 0;
    in_ready     = state_r == FS_IDLE;
    done         = state_r == FS_DONE;
    case (state_r)
      FS_IDLE: begin
        if (in_valid) begin
          req_nxt    = req;
          rd_cnt_nxt = '0;
          found_nxt  = 1'b0;
          cnt_nxt    = '0;
          seen_nxt   = '0;
          pass2_nxt  = 1'b0;
          rsp_nxt    = '0;
        end
      end
      FS_RD1: begin
        raddr    = IDX_W'(req_r.slot);
        ridx_nxt = raddr;
        issue    = 1'b1;
      end
      FS_MOD1: begin
        case (req_r.cmd)
          CMD_RUN: begin
            we = in_use;
            wdata.st = ST_RUNNABLE;
          end
          CMD_SLEEP: begin
            we = in_use;
            wdata.st   = ST_SLEEPING;
            wdata.chan = req_r.chan;
          end
          CMD_EXIT: begin
            we = in_use;
            wdata.st = ST_ZOMBIE;
          end
          CMD_FREE: begin
            we = 1'b1;
            wdata.st     = ST_UNUSED;
            wdata.pid    = '0;
            wdata.killed = 1'b0;
          end
          CMD_SET: begin
            we = 1'b1;
            wdata.pri   = req_r.pri;
            wdata.burst = req_r.burst;
          end
          default: we = 1'b0;
        endcase
      end
      FS_SCAN: begin
        if (rd_cnt_r != CNT_W'(SLOTS)) begin
          if ((req_r.cmd == CMD_PICK) && !(cfg.policy inside {[POL_OLDEST:POL_RANDOM]})) begin
            a = int'(rr_r) + int'(rd_cnt_r);
            if (a >= SLOTS) a = a - SLOTS;
            raddr = IDX_W'(a);
          end
          issue      = 1'b1;
          rv_nxt     = 1'b1;
          ridx_nxt   = raddr;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (rv_r) begin
          case (req_r.cmd)
            CMD_ALLOC: begin
              if (!found_r && !in_use) begin
                found_nxt    = 1'b1;
                best_idx_nxt = ridx_r;
                best_nxt         = eff;
                best_nxt.st      = ST_EMBRYO;
                best_nxt.pid     = pidc_r;
                best_nxt.created = req_r.tick;
                best_nxt.pri     = cfg.dpri;
                best_nxt.burst   = cfg.dburst;
              end
            end
            CMD_WAKE: begin
              if (eff.st == ST_SLEEPING && eff.chan == req_r.chan) begin
                we       = 1'b1;
                wdata.st = ST_RUNNABLE;
              end
            end
            CMD_KILL: begin
              if (!found_r && in_use && eff.pid == req_r.tpid) begin
                found_nxt       = 1'b1;
                best_idx_nxt    = ridx_r;
                best_nxt        = eff;
                best_nxt.killed = 1'b1;
                if (eff.st == ST_SLEEPING) best_nxt.st = ST_RUNNABLE;
              end
            end
            CMD_PICK: begin
              if (eff.st == ST_RUNNABLE) begin
                case (cfg.policy)
                  POL_OLDEST:   better = !found_r || eff.created < best_r.created;
                  POL_SHORTEST: better = !found_r || eff.burst < best_r.burst;
                  POL_PRIORITY: better = !found_r || eff.pri < best_r.pri ||
                                         (eff.pri == best_r.pri &&
                                          eff.created < best_r.created);
                  POL_RANDOM: begin
                    if (!pass2_r) begin
                      cnt_nxt = cnt_r + 1'b1;
                    end else begin
                      better   = !found_r && seen_r == target_r;
                      seen_nxt = seen_r + 1'b1;
                    end
                  end
                  default: better = !found_r;
                endcase
                if (better) begin
                  found_nxt    = 1'b1;
                  best_idx_nxt = ridx_r;
                  best_nxt     = eff;
                end
              end
            end
            default: we = 1'b0;
          endcase
        end
      end
      FS_FIN: begin
        waddr = best_idx_r;
        wdata = best_r;
        if (!(is_rand && !pass2_r && cnt_r != '0)) begin
          case (req_r.cmd)
            CMD_ALLOC: begin
              if (found_r) begin
                we       = 1'b1;
                pidc_nxt = pidc_r + 1'b1;
                rsp_nxt  = '{STAT_OK, 6'(best_idx_r), best_r.pid};
              end else begin
                rsp_nxt.status = STAT_NOFREE;
              end
            end
            CMD_KILL: begin
              if (found_r) begin
                we      = 1'b1;
                rsp_nxt = '{STAT_OK, 6'(best_idx_r), req_r.tpid};
              end else begin
                rsp_nxt.status = STAT_NOTFND;
              end
            end
            CMD_PICK: begin
              if (found_r) begin
                we       = 1'b1;
                wdata.st = ST_RUNNING;
                b = int'(best_idx_r) + 1;
                if (b >= SLOTS) b = 0;
                rr_nxt  = IDX_W'(b);
                rsp_nxt = '{STAT_OK, 6'(best_idx_r), best_r.pid};
              end else begin
                rsp_nxt.status = STAT_NORUN;
              end
            end
            default: we = 1'b0;
          endcase
        end
      end
      FS_LCG: begin
        lcg_nxt  = lcg_r * LCG_MUL + LCG_INC;
        dq_nxt   = lcg_r * LCG_MUL + LCG_INC;
        rem_nxt  = '0;
        dbit_nxt = '0;
      end
      FS_DIV: begin
        rem_nxt  = rem_new[CNT_W-1:0];
        dq_nxt   = {dq_r[30:0], 1'b0};
        dbit_nxt = dbit_r + 1'b1;
        if (dbit_r == 5'd31) begin
          target_nxt = rem_new[CNT_W-1:0];
          pass2_nxt  = 1'b1;
          rd_cnt_nxt = '0;
          seen_nxt   = '0;
          found_nxt  = 1'b0;
        end
      end
      default: we = 1'b0;
    endcase
    if (issue) rvld_nxt = valid_r[raddr];
    if (we) valid_nxt[waddr] = 1'b1;
  end

  assign rsp = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      rv_r    <= 1'b0;
      lcg_r   <= 32'd1;
      pidc_r  <= PID_W'(1);
      rr_r    <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      lcg_r   <= lcg_nxt;
      pidc_r  <= pidc_nxt;
      rr_r    <= rr_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    rvld_r     <= rvld_nxt;
    ridx_r     <= ridx_nxt;
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    cnt_r      <= cnt_nxt;
    seen_r     <= seen_nxt;
    target_r   <= target_nxt;
    pass2_r    <= pass2_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    dbit_r     <= dbit_nxt;
    rsp_r      <= rsp_nxt;
  end

endmodule

FILE: sv/task_table_scheduler.sv
// Top level of the task table scheduler: configuration registers, sequencer and result register.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_ready  | cmd, slot, target_pid, channel, tick_now, ...
//  out_    | output    | out_valid / out_ready| status, out_slot, out_pid
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Slot commands read only the slot given; alloc, wakeup, kill and pick scan the whole
//  table with one table memory read per cycle. Random pick makes two scans with a
//  remainder unit between them. One word is worked on at a time; a finished result waits in
//  the output register while the next word is accepted. Entries read as unused until
//  written.
`timescale 1ns / 1ps
module task_table_scheduler import tts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        in_cmd,
  input  logic [5:0]        in_slot,
  input  logic [PID_W-1:0]  in_target_pid,
  input  logic [31:0]       in_channel,
  input  logic [31:0]       in_tick_now,
  input  logic [7:0]        in_new_priority,
  input  logic [15:0]       in_new_burst,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [5:0]        out_slot,
  output logic [PID_W-1:0]  out_pid,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  rsp_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  req_t req;
  rsp_t rsp;
  logic done, done_ack;

  assign req = '{in_cmd, in_slot, in_target_pid, in_channel, in_tick_now,
                 in_new_priority, in_new_burst};

  tts_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req      (req),
    .cfg      (cfg_r),
    .done     (done),
    .done_ack (done_ack),
    .rsp      (rsp)
  );

  assign cfg_ready = 1'b1;
  assign done_ack  = !out_valid_r || out_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_POLICY: cfg_nxt.policy = cfg_data[2:0];
        REG_DPRI:   cfg_nxt.dpri   = cfg_data[7:0];
        REG_DBURST: cfg_nxt.dburst = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (done && done_ack) begin
      out_nxt       = rsp;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{POL_OLDEST, DEF_PRI, DEF_BURST};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_r.status;
  assign out_slot   = out_r.slot;
  assign out_pid    = out_r.pid;

endmodule
